FILE: hw/rtl/utf8dec_pkg.sv
package utf8dec_pkg;

    localparam logic [15:0] UNIT_ERR  = 16'h003F;
    localparam logic [15:0] UNIT_TERM = 16'h0000;
    localparam int unsigned MAX_DATA  = 3;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        final_unit;
    } t_out;

    // All results caused by one input item: up to three data units,
    // optionally followed by the terminator.
    typedef struct packed {
        logic [MAX_DATA-1:0][15:0] units;
        logic [1:0]                n_data;
        logic                      fin;
    } t_bundle;

    function automatic logic is_ascii(input logic [7:0] b);
        return b[7] == 1'b0;
    endfunction

    function automatic logic is_lead2(input logic [7:0] b);
        return (b & 8'hE0) == 8'hC0;
    endfunction

    function automatic logic is_lead3(input logic [7:0] b);
        return (b & 8'hF0) == 8'hE0;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & 8'hC0) == 8'h80;
    endfunction

    function automatic logic is_leadlike(input logic [7:0] b);
        return is_ascii(b) || is_lead2(b) || is_lead3(b);
    endfunction

endpackage

FILE: hw/rtl/utf8dec_front.sv
module utf8dec_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  utf8dec_pkg::t_in     i_item,
    input  logic                 i_q_full,
    output logic                 o_full,
    output logic                 o_enq,
    output utf8dec_pkg::t_bundle o_bundle
);
    import utf8dec_pkg::*;

    logic [1:0]      r_held_count, n_held_count;
    logic [7:0]      r_held0, n_held0;
    logic [7:0]      r_held1, n_held1;

    logic [3:0][7:0] w;
    logic [1:0]      n;
    logic [1:0]      pos;
    logic [1:0]      k;
    logic [1:0]      avail;
    logic            done;
    logic            fin;
    logic            accept;
    logic [7:0]      b0, b1, b2;
    logic [MAX_DATA-1:0][15:0] units;

    assign fin    = i_item.end_of_input;
    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    // Decode the window of held bytes plus the new byte. Every pass either
    // emits one unit and consumes at least one byte, or ends the walk, so
    // three passes cover the longest window.
    always_comb begin
        w     = '0;
        n     = 2'd1;
        pos   = 2'd0;
        k     = 2'd0;
        done  = 1'b0;
        units = '0;
        avail = 2'd0;
        b0    = 8'h00;
        b1    = 8'h00;
        b2    = 8'h00;
        case (r_held_count)
            2'd1: begin
                w[0] = r_held0;
                w[1] = i_item.byte_in;
                n    = 2'd2;
            end
            2'd2: begin
                w[0] = r_held0;
                w[1] = r_held1;
                w[2] = i_item.byte_in;
                n    = 2'd3;
            end
            default: begin
                w[0] = i_item.byte_in;
                n    = 2'd1;
            end
        endcase
        for (int it = 0; it < MAX_DATA; it++) begin
            if (!done && pos < n) begin
                b0    = w[pos];
                b1    = w[pos + 2'd1];
                b2    = w[pos + 2'd2];
                avail = n - pos;
                if (is_ascii(b0)) begin
                    units[k] = {8'h00, b0};
                    k        = k + 2'd1;
                    pos      = pos + 2'd1;
                end else if (is_lead2(b0)) begin
                    if (avail < 2'd2) begin
                        if (fin) begin
                            units[k] = UNIT_ERR;
                            k        = k + 2'd1;
                        end
                        done = 1'b1;
                    end else if (is_cont(b1)) begin
                        units[k] = {5'b00000, b0[4:0], b1[5:0]};
                        k        = k + 2'd1;
                        pos      = pos + 2'd2;
                    end else if (is_leadlike(b1)) begin
                        units[k] = UNIT_ERR;
                        k        = k + 2'd1;
                        pos      = pos + 2'd1;
                    end else begin
                        units[k] = UNIT_ERR;
                        k        = k + 2'd1;
                        pos      = pos + 2'd2;
                    end
                end else if (is_lead3(b0)) begin
                    if (avail < 2'd3) begin
                        if (!fin) begin
                            done = 1'b1;
                        end else if (avail < 2'd2) begin
                            units[k] = UNIT_ERR;
                            k        = k + 2'd1;
                            done     = 1'b1;
                        end else if (is_ascii(b1)) begin
                            units[k] = UNIT_ERR;
                            k        = k + 2'd1;
                            pos      = pos + 2'd1;
                        end else begin
                            units[k] = UNIT_ERR;
                            k        = k + 2'd1;
                            done     = 1'b1;
                        end
                    end else if (is_cont(b1) && is_cont(b2)) begin
                        units[k] = {b0[3:0], b1[5:0], b2[5:0]};
                        k        = k + 2'd1;
                        pos      = pos + 2'd3;
                    end else if (is_leadlike(b1)) begin
                        units[k] = UNIT_ERR;
                        k        = k + 2'd1;
                        pos      = pos + 2'd1;
                    end else if (is_leadlike(b2)) begin
                        units[k] = UNIT_ERR;
                        k        = k + 2'd1;
                        pos      = pos + 2'd2;
                    end else begin
                        units[k] = UNIT_ERR;
                        k        = k + 2'd1;
                        pos      = pos + 2'd3;
                    end
                end else begin
                    units[k] = UNIT_ERR;
                    k        = k + 2'd1;
                    pos      = pos + 2'd1;
                end
            end
        end
    end

    always_comb begin
        n_held_count = r_held_count;
        n_held0      = r_held0;
        n_held1      = r_held1;
        if (accept) begin
            if (fin) begin
                n_held_count = 2'd0;
            end else begin
                // A walk that stops short always leaves at most two bytes.
                n_held_count = n - pos;
                n_held0      = w[pos];
                n_held1      = w[pos + 2'd1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 2'd0;
        end else begin
            r_held_count <= n_held_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held0 <= n_held0;
        r_held1 <= n_held1;
    end

    assign o_enq           = accept && (k != 2'd0 || fin);
    assign o_bundle.units  = units;
    assign o_bundle.n_data = k;
    assign o_bundle.fin    = fin;

endmodule

FILE: hw/rtl/utf8dec_queue.sv
module utf8dec_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_enq,
    input  utf8dec_pkg::t_bundle i_bundle,
    input  logic                 i_deq,
    output logic                 o_full,
    output logic                 o_valid,
    output utf8dec_pkg::t_bundle o_head
);
    import utf8dec_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_bundle          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_enq;
    logic             do_deq;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_enq  = i_enq && !o_full;
    assign do_deq  = i_deq && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_enq) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_deq) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_enq && !do_deq) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_deq && !do_enq) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_enq) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

endmodule

FILE: hw/rtl/utf8dec_back.sv
module utf8dec_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  utf8dec_pkg::t_bundle i_head,
    input  logic                 i_pop,
    output logic                 o_deq,
    output logic                 o_empty,
    output utf8dec_pkg::t_out    o_item
);
    import utf8dec_pkg::*;

    logic [1:0] r_sub, n_sub;
    logic [2:0] total;
    logic       is_data;
    logic       take;
    logic       last;

    assign total   = {1'b0, i_head.n_data} + {2'b00, i_head.fin};
    assign is_data = (r_sub < i_head.n_data);
    assign last    = ({1'b0, r_sub} + 3'd1 == total);
    assign take    = i_pop && i_valid;

    assign o_empty           = !i_valid;
    assign o_item.code_unit  = is_data ? i_head.units[r_sub] : UNIT_TERM;
    assign o_item.final_unit = !is_data;
    assign o_deq             = take && last;

    // Walk through the units of the head bundle one item at a time.
    always_comb begin
        n_sub = r_sub;
        if (take) begin
            n_sub = last ? 2'd0 : r_sub + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 2'd0;
        end else begin
            r_sub <= n_sub;
        end
    end

endmodule

FILE: hw/rtl/utf8_to_ucs2_decoder_unit.sv
// UTF-8 to UCS-2 decoder. Bytes go in through a push/full port, one byte per
// item together with an end-of-input flag; 16-bit code units come out through an
// empty/pop port. One-, two- and three-byte sequences decode to their value,
// malformed or truncated sequences give 0x003F, and after the byte flagged as
// last a zero unit with final_unit set closes the stream. The front end takes
// one byte every cycle unless full and decodes it at once against the up to two
// bytes it holds back; all units caused by that byte go into a QUEUE_DEPTH-entry
// queue as one entry. The back end hands out one unit per cycle while pop is
// high, so a byte yields zero to four output items and the sustained input rate
// is one byte per cycle whenever each byte yields at most one unit. full rises
// only when the queue holds QUEUE_DEPTH entries still being drained.
module utf8_to_ucs2_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  utf8dec_pkg::t_in  i_item,
    output logic              o_full,
    output logic              o_empty,
    input  logic              i_pop,
    output utf8dec_pkg::t_out o_item
);
    import utf8dec_pkg::*;

    t_bundle enq_bundle;
    t_bundle head_bundle;
    logic    enq;
    logic    deq;
    logic    q_full;
    logic    q_valid;

    utf8dec_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_full   (o_full),
        .o_enq    (enq),
        .o_bundle (enq_bundle)
    );

    utf8dec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enq    (enq),
        .i_bundle (enq_bundle),
        .i_deq    (deq),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_head   (head_bundle)
    );

    utf8dec_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_head  (head_bundle),
        .i_pop   (i_pop),
        .o_deq   (deq),
        .o_empty (o_empty),
        .o_item  (o_item)
    );

`ifndef SYNTHESIS
    a_final_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_item.final_unit) |-> (o_item.code_unit == UNIT_TERM))
        else $error("final item carries a nonzero code unit");

    a_full_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !o_empty)
        else $error("input side full while no result is waiting");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && i_item.end_of_input) |=> !o_empty)
        else $error("last byte accepted but no result queued");
`endif

endmodule

FILE: bench/utf8_to_ucs2_decoder_unit_tb.sv
module utf8_to_ucs2_decoder_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import utf8dec_pkg::*;

    localparam int RANDOM_ITEMS = 283;
    localparam int DIR_ROWS     = 27;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [2:0] {
        BC_ASCII,
        BC_LEAD2,
        BC_LEAD3,
        BC_CONT,
        BC_OTHER
    } t_byte_class;

    // One directed byte. Where typed is set, the units listed in data (first unit
    // in the leftmost slot) are what the byte must produce, and a last byte adds
    // the terminator on top of them.
    typedef struct packed {
        logic [7:0]       byte_val;
        logic             last;
        logic             typed;
        logic [1:0]       n_data;
        logic [2:0][15:0] data;
    } t_dir_row;

    localparam logic [15:0] NO_U = 16'h0000;
    localparam t_out TERM_UNIT = '{code_unit: UNIT_TERM, final_unit: 1'b1};

    localparam t_dir_row STIM_TABLE [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 2'd1, {16'h0000, NO_U, NO_U}},
        '{8'h80, 1'b0, 1'b1, 2'd1, {UNIT_ERR, NO_U, NO_U}},
        '{8'hFF, 1'b0, 1'b1, 2'd1, {UNIT_ERR, NO_U, NO_U}},
        '{8'hDF, 1'b0, 1'b1, 2'd0, {NO_U, NO_U, NO_U}},
        '{8'hBF, 1'b0, 1'b0, 2'd0, {NO_U, NO_U, NO_U}},
        '{8'hE0, 1'b0, 1'b1, 2'd0, {NO_U, NO_U, NO_U}},
        '{8'h80, 1'b0, 1'b1, 2'd0, {NO_U, NO_U, NO_U}},
        '{8'h80, 1'b0, 1'b0, 2'd0, {NO_U, NO_U, NO_U}},
        '{8'hEF, 1'b0, 1'b1, 2'd0, {NO_U, NO_U, NO_U}},
        '{8'hBF, 1'b0, 1'b1, 2'd0, {NO_U, NO_U, NO_U}},
        '{8'hBF, 1'b0, 1'b0, 2'd0, {NO_U, NO_U, NO_U}},
        // Three-byte lead cut short by a two-byte lead, which is itself cut short.
        '{8'hE1, 1'b0, 1'b1, 2'd0, {NO_U, NO_U, NO_U}},
        '{8'hC3, 1'b0, 1'b1, 2'd0, {NO_U, NO_U, NO_U}},
        '{8'h7F, 1'b1, 1'b1, 2'd3, {UNIT_ERR, UNIT_ERR, 16'h007F}},
        '{8'hE1, 1'b0, 1'b1, 2'd0, {NO_U, NO_U, NO_U}},
        '{8'h80, 1'b0, 1'b1, 2'd0, {NO_U, NO_U, NO_U}},
        '{8'hC3, 1'b0, 1'b1, 2'd1, {UNIT_ERR, NO_U, NO_U}},
        '{8'hF5, 1'b0, 1'b1, 2'd1, {UNIT_ERR, NO_U, NO_U}},
        '{8'hE1, 1'b0, 1'b1, 2'd0, {NO_U, NO_U, NO_U}},
        '{8'h80, 1'b0, 1'b1, 2'd0, {NO_U, NO_U, NO_U}},
        '{8'hF8, 1'b0, 1'b1, 2'd1, {UNIT_ERR, NO_U, NO_U}},
        '{8'hC5, 1'b1, 1'b1, 2'd1, {UNIT_ERR, NO_U, NO_U}},
        '{8'hE2, 1'b1, 1'b1, 2'd1, {UNIT_ERR, NO_U, NO_U}},
        '{8'hE2, 1'b0, 1'b1, 2'd0, {NO_U, NO_U, NO_U}},
        '{8'h41, 1'b1, 1'b1, 2'd2, {UNIT_ERR, 16'h0041, NO_U}},
        '{8'hE2, 1'b0, 1'b1, 2'd0, {NO_U, NO_U, NO_U}},
        '{8'h85, 1'b1, 1'b1, 2'd1, {UNIT_ERR, NO_U, NO_U}}
    };

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_push  = 1'b0;
    t_in  i_item  = '0;
    logic i_pop   = 1'b0;
    logic o_full;
    logic o_empty;
    t_out o_item;

    // Decoder state as the bench sees it: bytes held back for lookahead.
    logic [7:0] lookahead [2];
    int         lookahead_cnt = 0;

    t_out units_due [$];
    int   errors         = 0;
    int   units_checked  = 0;
    int   bytes_sent     = 0;
    int   streams_closed = 0;
    bit   push_steady    = 1'b0;
    bit   pop_steady     = 1'b0;
    int   pop_wait       = 0;

    utf8_to_ucs2_decoder_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (i_item),
        .o_full  (o_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("%0t: run did not finish in time", $time);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_byte_class classify(input logic [7:0] b);
        if (b[7] == 1'b0)
            return BC_ASCII;
        if (b[7:5] == 3'b110)
            return BC_LEAD2;
        if (b[7:4] == 4'b1110)
            return BC_LEAD3;
        if (b[7:6] == 2'b10)
            return BC_CONT;
        return BC_OTHER;
    endfunction

    function automatic bit starts_sequence(input t_byte_class c);
        return c == BC_ASCII || c == BC_LEAD2 || c == BC_LEAD3;
    endfunction

    function automatic t_out data_unit(input logic [15:0] v);
        return '{code_unit: v, final_unit: 1'b0};
    endfunction

    function automatic int pick_gap(input bit steady);
        if (steady)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(0, 2);
    endfunction

    function automatic logic [7:0] rand_byte(input logic [7:0] fixed, input logic [7:0] mask);
        logic [7:0] r;
        r = 8'($urandom);
        return fixed | (r & mask);
    endfunction

    // Decodes one byte against the held lookahead, puts the units it causes in
    // res and returns their count; updates the lookahead.
    function automatic int decode_byte(input t_in it, output t_out res [4]);
        logic [7:0]  win [3];
        int          n;
        int          pos;
        int          k;
        int          avail;
        bit          done;
        t_byte_class c0;
        t_byte_class c1;
        t_byte_class c2;
        n = 0;
        pos = 0;
        k = 0;
        done = 1'b0;
        for (int i = 0; i < lookahead_cnt; i++) begin
            win[n] = lookahead[i];
            n++;
        end
        win[n] = it.byte_in;
        n++;

        while (pos < n && !done) begin
            c0 = classify(win[pos]);
            avail = n - pos;
            case (c0)
                BC_ASCII: begin
                    res[k] = data_unit({8'h00, win[pos]});
                    k++;
                    pos += 1;
                end
                BC_LEAD2: begin
                    if (avail < 2) begin
                        if (it.end_of_input) begin
                            res[k] = data_unit(UNIT_ERR);
                            k++;
                        end
                        done = 1'b1;
                    end else begin
                        c1 = classify(win[pos + 1]);
                        if (c1 == BC_CONT) begin
                            res[k] = data_unit({5'b0, win[pos][4:0], win[pos + 1][5:0]});
                            pos += 2;
                        end else begin
                            res[k] = data_unit(UNIT_ERR);
                            pos += (c1 == BC_OTHER) ? 2 : 1;
                        end
                        k++;
                    end
                end
                BC_LEAD3: begin
                    if (avail < 3) begin
                        // At the end of the stream a short three-byte lead gives
                        // an error; an ASCII byte behind it still decodes.
                        if (it.end_of_input) begin
                            res[k] = data_unit(UNIT_ERR);
                            k++;
                            if (avail >= 2 && classify(win[pos + 1]) == BC_ASCII)
                                pos += 1;
                            else
                                done = 1'b1;
                        end else begin
                            done = 1'b1;
                        end
                    end else begin
                        c1 = classify(win[pos + 1]);
                        c2 = classify(win[pos + 2]);
                        if (c1 == BC_CONT && c2 == BC_CONT) begin
                            res[k] = data_unit({win[pos][3:0], win[pos + 1][5:0],
                                                win[pos + 2][5:0]});
                            pos += 3;
                        end else begin
                            res[k] = data_unit(UNIT_ERR);
                            if (starts_sequence(c1))
                                pos += 1;
                            else if (starts_sequence(c2))
                                pos += 2;
                            else
                                pos += 3;
                        end
                        k++;
                    end
                end
                default: begin
                    res[k] = data_unit(UNIT_ERR);
                    k++;
                    pos += 1;
                end
            endcase
        end

        if (it.end_of_input) begin
            res[k] = TERM_UNIT;
            k++;
            lookahead_cnt = 0;
        end else begin
            lookahead_cnt = (n - pos > 2) ? 2 : n - pos;
            for (int i = 0; i < lookahead_cnt; i++)
                lookahead[i] = win[pos + i];
        end
        return k;
    endfunction

    task automatic push_byte(input t_in it);
        int gap;
        gap = pick_gap(push_steady);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_full);
        bytes_sent++;
        if (it.end_of_input)
            streams_closed++;
    endtask

    task automatic send_predicted(input t_in it);
        t_out got [4];
        int   n;
        push_byte(it);
        n = decode_byte(it, got);
        for (int i = 0; i < n; i++)
            units_due.push_back(got[i]);
    endtask

    // Result side: random stalls, with stretches where pop stays high.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            pop_steady <= !pop_steady;
        if (pop_wait > 0) begin
            pop_wait <= pop_wait - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= 1'b1;
            pop_wait <= pick_gap(pop_steady);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (units_due.size() == 0) begin
                $display("%0t: unexpected unit, expected none, got %h final %b",
                         $time, o_item.code_unit, o_item.final_unit);
                errors++;
            end else begin
                want = units_due.pop_front();
                units_checked++;
                if (o_item.code_unit !== want.code_unit) begin
                    $display("%0t: code_unit mismatch, expected %h, got %h",
                             $time, want.code_unit, o_item.code_unit);
                    errors++;
                end
                if (o_item.final_unit !== want.final_unit) begin
                    $display("%0t: final_unit mismatch, expected %b, got %b",
                             $time, want.final_unit, o_item.final_unit);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_in        it;
        t_out       scratch [4];
        logic [7:0] chunk [$];
        int         pick;
        int         random_sent;
        random_sent = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            it.byte_in = STIM_TABLE[r].byte_val;
            it.end_of_input = STIM_TABLE[r].last;
            if (STIM_TABLE[r].typed) begin
                push_byte(it);
                void'(decode_byte(it, scratch));
                for (int i = 0; i < STIM_TABLE[r].n_data; i++)
                    units_due.push_back(data_unit(STIM_TABLE[r].data[2 - i]));
                if (STIM_TABLE[r].last)
                    units_due.push_back(TERM_UNIT);
            end else begin
                send_predicted(it);
            end
        end

        // Mostly well-formed characters with random payload, plus broken
        // sequences and raw noise; streams end at random points.
        while (random_sent < RANDOM_ITEMS) begin
            chunk.delete();
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                chunk.push_back(rand_byte(8'h00, 8'h7F));
            end else if (pick < 55) begin
                chunk.push_back(rand_byte(8'hC0, 8'h1F));
                chunk.push_back(rand_byte(8'h80, 8'h3F));
            end else if (pick < 75) begin
                chunk.push_back(rand_byte(8'hE0, 8'h0F));
                chunk.push_back(rand_byte(8'h80, 8'h3F));
                chunk.push_back(rand_byte(8'h80, 8'h3F));
            end else if (pick < 88) begin
                if ($urandom_range(0, 1) == 0)
                    chunk.push_back(rand_byte(8'hC0, 8'h1F));
                else
                    chunk.push_back(rand_byte(8'hE0, 8'h0F));
                repeat ($urandom_range(0, 2))
                    chunk.push_back(rand_byte(8'h00, 8'hFF));
            end else begin
                chunk.push_back(rand_byte(8'h00, 8'hFF));
            end

            foreach (chunk[j]) begin
                it.byte_in = chunk[j];
                it.end_of_input = (j == chunk.size() - 1) && ($urandom_range(0, 11) == 0);
                send_predicted(it);
                random_sent++;
            end
            if ($urandom_range(0, 39) == 0)
                push_steady = !push_steady;
        end

        i_push <= 1'b0;
        while (units_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Pushed %0d bytes (%0d from the directed table) in %0d closed streams.",
                 bytes_sent, DIR_ROWS, streams_closed);
        $display("Checked %0d code units, %0d mismatches.", units_checked, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
